/* sv/step_record_statistics_defines.svh */
// Assertion macros shared by the step record statistics RTL.
`ifndef STEP_RECORD_STATISTICS_DEFINES_SVH
`define STEP_RECORD_STATISTICS_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property under the local clock and reset.
`define SRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define SRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SRS_ASSERT(lbl, prop, msg)
`define SRS_ASSERT_IMP(lbl, ante, cons, msg)
`define SRS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/srs_pkg.sv */
// Shared constants and types for the step record statistics block.
`timescale 1ns / 1ps

package srs_pkg;

  // Data set and sample sizing
  localparam int MAX_RECORDS = 1024;
  localparam int SAMPLE_BITS = 16;

  // Fixed port widths
  localparam int STEP_W  = 16;
  localparam int THR_W   = 16;
  localparam int TOTAL_W = 11;
  localparam int INDEX_W = 10;
  localparam int MEAN_W  = 16;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(500);

  // Derived internal widths
  localparam int IDX_W  = $clog2(MAX_RECORDS);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int DVD_W  = SUM_W + 2;
  localparam int DVS_W  = CNT_W + 1;
  localparam int STEP_CNT_W = $clog2(DVD_W + 1);

  // Statistics held for the current data set
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] min_pos;
    logic [IDX_W-1:0] max_pos;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] best_start;
    logic [CNT_W-1:0] best_len;
  } srs_stats_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } srs_div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
  } srs_div_rsp_t;

endpackage

/* sv/srs_stats.sv */
// Running minimum, maximum, sum and longest-run tracker, one sample a cycle while below capacity.
`timescale 1ns / 1ps

module srs_stats (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic                             clear_i,
  input  logic [srs_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic [srs_pkg::THR_W-1:0]        threshold_i,
  output srs_pkg::srs_stats_t              stats_o
);
  import srs_pkg::*;

  logic [CNT_W-1:0]       count_q, count_d;
  logic [SAMPLE_BITS-1:0] min_val_q, min_val_d;
  logic [SAMPLE_BITS-1:0] max_val_q, max_val_d;
  logic [IDX_W-1:0]       min_pos_q, min_pos_d;
  logic [IDX_W-1:0]       max_pos_q, max_pos_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [IDX_W-1:0]       cur_start_q, cur_start_d;
  logic [CNT_W-1:0]       cur_len_q, cur_len_d;
  logic [IDX_W-1:0]       best_start_q, best_start_d;
  logic [CNT_W-1:0]       best_len_q, best_len_d;

  logic             room;
  logic             first;
  logic             above;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] run_start;
  logic [CNT_W-1:0] run_len;

  assign room      = count_q < CNT_W'(MAX_RECORDS);
  assign first     = count_q == '0;
  assign idx       = count_q[IDX_W-1:0];
  assign above     = CMP_W'(sample_i) > CMP_W'(threshold_i);
  assign run_start = (cur_len_q == '0) ? idx : cur_start_q;
  assign run_len   = cur_len_q + CNT_W'(1);

  // Fold one sample into the statistics, or clear them after a result
  always_comb begin
    count_d      = count_q;
    min_val_d    = min_val_q;
    max_val_d    = max_val_q;
    min_pos_d    = min_pos_q;
    max_pos_d    = max_pos_q;
    sum_d        = sum_q;
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    if (clear_i) begin
      count_d      = '0;
      min_val_d    = '0;
      max_val_d    = '0;
      min_pos_d    = '0;
      max_pos_d    = '0;
      sum_d        = '0;
      cur_start_d  = '0;
      cur_len_d    = '0;
      best_start_d = '0;
      best_len_d   = '0;
    end else if (take_i && room) begin
      if (first || (sample_i < min_val_q)) begin
        min_val_d = sample_i;
        min_pos_d = idx;
      end
      if (first || (sample_i > max_val_q)) begin
        max_val_d = sample_i;
        max_pos_d = idx;
      end
      sum_d = sum_q + SUM_W'(sample_i);
      if (above) begin
        cur_start_d = run_start;
        cur_len_d   = run_len;
        // Strictly longer only, so the earliest run keeps a tie
        if (run_len > best_len_q) begin
          best_start_d = run_start;
          best_len_d   = run_len;
        end
      end else begin
        cur_len_d = '0;
      end
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      min_val_q    <= '0;
      max_val_q    <= '0;
      min_pos_q    <= '0;
      max_pos_q    <= '0;
      sum_q        <= '0;
      cur_start_q  <= '0;
      cur_len_q    <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
    end else begin
      count_q      <= count_d;
      min_val_q    <= min_val_d;
      max_val_q    <= max_val_d;
      min_pos_q    <= min_pos_d;
      max_pos_q    <= max_pos_d;
      sum_q        <= sum_d;
      cur_start_q  <= cur_start_d;
      cur_len_q    <= cur_len_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
    end
  end

  assign stats_o.count      = count_q;
  assign stats_o.min_pos    = min_pos_q;
  assign stats_o.max_pos    = max_pos_q;
  assign stats_o.sum        = sum_q;
  assign stats_o.best_start = best_start_q;
  assign stats_o.best_len   = best_len_q;

endmodule

/* sv/srs_div.sv */
// Restoring divider, one quotient bit per cycle, used for the rounded mean.
`timescale 1ns / 1ps

module srs_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srs_pkg::srs_div_req_t req_i,
  output srs_pkg::srs_div_rsp_t rsp_o
);
  import srs_pkg::*;

  logic [STEP_CNT_W-1:0] steps_q, steps_d;
  logic [DVS_W-1:0]      rem_q, rem_d;
  logic [DVD_W-1:0]      quo_q, quo_d;
  logic [DVS_W-1:0]      dvs_q, dvs_d;

  logic [DVS_W:0] trial;
  logic           fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // Load on start, then shift in one dividend bit and try a subtract
  always_comb begin
    steps_d = steps_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      steps_d = STEP_CNT_W'(DVD_W);
      rem_d   = '0;
      quo_d   = req_i.dividend;
      dvs_d   = req_i.divisor;
    end else if (steps_q != '0) begin
      steps_d = steps_q - STEP_CNT_W'(1);
      rem_d   = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_d   = {quo_q[DVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else begin
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = steps_q != '0;
  assign rsp_o.quotient = quo_q;

endmodule

/* sv/step_record_statistics.sv */
// Top level of the step record statistics block: sequencer, threshold and result register.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------------
//  in      | in        | in_valid_i / in_stall_o     | step_count_i, last_record_i
//  out     | out       | out_valid_o / out_stall_i   | record_total_o .. run_end_index_o
//  cfg     | in        | run_threshold_we_i          | run_threshold_i
//
// An ordinary sample beat is taken while idle. A flagged beat holds the input stalled through a
// load state, a bit-serial divider step per dividend bit for the rounded mean, and a hand-over.
// The hand-over waits while a previous result beat is still stalled at the output.
// Reset clears the statistics and loads the threshold with 500.
`timescale 1ns / 1ps

`include "step_record_statistics_defines.svh"

module step_record_statistics (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        run_threshold_we_i,
  input  logic [srs_pkg::THR_W-1:0]   run_threshold_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [srs_pkg::STEP_W-1:0]  step_count_i,
  input  logic                        last_record_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srs_pkg::TOTAL_W-1:0] record_total_o,
  output logic [srs_pkg::INDEX_W-1:0] fewest_index_o,
  output logic [srs_pkg::INDEX_W-1:0] largest_index_o,
  output logic [srs_pkg::MEAN_W-1:0]  mean_rounded_o,
  output logic                        run_found_o,
  output logic [srs_pkg::INDEX_W-1:0] run_start_index_o,
  output logic [srs_pkg::INDEX_W-1:0] run_end_index_o
);
  import srs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV
  } state_e;

  state_e state_q;

  logic [THR_W-1:0] thr_q;

  logic               out_valid_q;
  logic [TOTAL_W-1:0] total_q;
  logic [INDEX_W-1:0] fewest_q;
  logic [INDEX_W-1:0] largest_q;
  logic [MEAN_W-1:0]  mean_q;
  logic               found_q;
  logic [INDEX_W-1:0] start_q;
  logic [INDEX_W-1:0] end_q;

  srs_stats_t   stats;
  srs_div_req_t div_req;
  srs_div_rsp_t div_rsp;

  logic             in_beat;
  logic             out_free;
  logic             finish;
  logic             run_any;
  logic [CNT_W-1:0] run_last;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == ST_DIV) && !div_rsp.busy && out_free;
  assign run_any  = stats.best_len != '0;
  assign run_last = CNT_W'(stats.best_start) + stats.best_len - CNT_W'(1);

  // Hold the run threshold across data sets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RESET;
    end else if (run_threshold_we_i) begin
      thr_q <= run_threshold_i;
    end
  end

  srs_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_beat),
    .clear_i     (finish),
    .sample_i    (step_count_i[SAMPLE_BITS-1:0]),
    .threshold_i (thr_q),
    .stats_o     (stats)
  );

  // Mean rounded half up: (2*sum + count) / (2*count)
  assign div_req.start    = state_q == ST_LAUNCH;
  assign div_req.dividend = {stats.sum, 1'b0} + DVD_W'(stats.count);
  assign div_req.divisor  = {stats.count, 1'b0};

  srs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequence a flagged beat through the divider and into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat && last_record_i) begin
            state_q <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded as the set closes
  always_ff @(posedge clk_i) begin
    if (finish) begin
      total_q   <= TOTAL_W'(stats.count);
      fewest_q  <= INDEX_W'(stats.min_pos);
      largest_q <= INDEX_W'(stats.max_pos);
      mean_q    <= div_rsp.quotient[MEAN_W-1:0];
      found_q   <= run_any;
      start_q   <= run_any ? INDEX_W'(stats.best_start) : '0;
      end_q     <= run_any ? INDEX_W'(run_last) : '0;
    end
  end

  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign record_total_o    = total_q;
  assign fewest_index_o    = fewest_q;
  assign largest_index_o   = largest_q;
  assign mean_rounded_o    = mean_q;
  assign run_found_o       = found_q;
  assign run_start_index_o = start_q;
  assign run_end_index_o   = end_q;

  `SRS_ASSERT_NXT(a_last_launches, in_beat && last_record_i, state_q == ST_LAUNCH, "flagged beat did not launch the divider")
  `SRS_ASSERT_IMP(a_idle_div_quiet, state_q == ST_IDLE, !div_rsp.busy, "divider busy while input is open")
  `SRS_ASSERT_IMP(a_result_from_div, $rose(out_valid_q), $past(state_q == ST_DIV), "result raised outside divider wait")
  `SRS_ASSERT(a_count_bound, stats.count <= CNT_W'(MAX_RECORDS), "sample count beyond capacity")

endmodule
